// File: sv/socks5rp_pkg.sv
`timescale 1ns / 1ps

package socks5rp_pkg;

   localparam logic [3:0] CODE_VERSION = 4'd0;
   localparam logic [3:0] CODE_CMD     = 4'd1;
   localparam logic [3:0] CODE_RSV     = 4'd2;
   localparam logic [3:0] CODE_ATYP    = 4'd3;
   localparam logic [3:0] CODE_NAMELEN = 4'd4;
   localparam logic [3:0] CODE_ADDR    = 4'd5;
   localparam logic [3:0] CODE_PORT    = 4'd6;
   localparam logic [3:0] CODE_ERROR   = 4'd7;
   localparam logic [3:0] CODE_END     = 4'd8;

   localparam logic [7:0] SOCKS_VER   = 8'd5;
   localparam logic [7:0] CMD_CONNECT = 8'd1;
   localparam logic [7:0] RSV_BYTE    = 8'h00;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_IPV4   = 3'd1;
   localparam logic [2:0] KIND_DOMAIN = 3'd3;
   localparam logic [2:0] KIND_IPV6   = 3'd4;

   localparam logic [7:0] LEN_IPV4 = 8'd4;
   localparam logic [7:0] LEN_IPV6 = 8'd16;

   typedef enum logic [8:0] {
      PH_VERSION = 9'b000000001,
      PH_CMD     = 9'b000000010,
      PH_RSV     = 9'b000000100,
      PH_ATYP    = 9'b000001000,
      PH_NAMELEN = 9'b000010000,
      PH_ADDR    = 9'b000100000,
      PH_PORT    = 9'b001000000,
      PH_ERROR   = 9'b010000000,
      PH_END     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic       restart;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic        reply_status;
      logic        request_done;
      logic        request_error;
      logic [2:0]  addr_kind;
      logic        addr_valid;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      logic [15:0] dest_port;
   } rsp_type;

   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_VERSION: code = CODE_VERSION;
         PH_CMD:     code = CODE_CMD;
         PH_RSV:     code = CODE_RSV;
         PH_ATYP:    code = CODE_ATYP;
         PH_NAMELEN: code = CODE_NAMELEN;
         PH_ADDR:    code = CODE_ADDR;
         PH_PORT:    code = CODE_PORT;
         PH_END:     code = CODE_END;
         default:    code = CODE_ERROR;
      endcase
      return code;
   endfunction

endpackage

// File: sv/socks5rp_ifs.sv
`timescale 1ns / 1ps

interface socks5rp_req_if;
   logic       valid;
   logic       ready;
   logic       restart;
   logic [7:0] data_byte;

   modport source (output valid, output restart, output data_byte, input ready);
   modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface socks5rp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  phase;
   logic        reply_status;
   logic        request_done;
   logic        request_error;
   logic [2:0]  addr_kind;
   logic        addr_valid;
   logic [7:0]  addr_byte;
   logic [7:0]  addr_index;
   logic [15:0] dest_port;

   modport source (
      output valid, output phase, output reply_status, output request_done,
      output request_error, output addr_kind, output addr_valid, output addr_byte,
      output addr_index, output dest_port, input ready
   );
   modport sink (
      input valid, input phase, input reply_status, input request_done,
      input request_error, input addr_kind, input addr_valid, input addr_byte,
      input addr_index, input dest_port, output ready
   );
endinterface

// File: sv/socks5_request_parser.sv
`timescale 1ns / 1ps
// SOCKS5 request parser.
// req_ch carries one request byte per item (data_byte) and a restart flag
// that puts the parser back to the version phase before that byte is used.
// rsp_ch returns exactly one item per accepted byte: the phase after the
// byte, reply status, done/error flags, the address type, the streamed
// address byte with its index (addr_valid marks it), and the assembled port.
// Both channels use valid/ready; an item moves when both are high.
// A byte accepted into the input register moves into the result register
// and from there shows on rsp_ch, unless the receiver is stalling.
// Throughput is one byte per cycle while the receiver does not stall;
// the parse state updates as an item moves from the input register into
// the result register.
// When the receiver stalls, the result register holds, the input register
// fills, and req_ch.ready drops only when both are full.
// Synchronous reset empties both registers and puts the parser into the
// version phase with status succeeded, no address type and port 0.

module socks5_request_parser
   import socks5rp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   socks5rp_req_if.sink   req_ch,
   socks5rp_rsp_if.source rsp_ch
);

   logic    item_valid;
   req_type item;
   logic    can_load;
   logic    advance;
   rsp_type result;

   assign advance = item_valid && can_load;

   socks5rp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   socks5rp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   socks5rp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .can_load   (can_load),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: sv/socks5rp_in_stage.sv
`timescale 1ns / 1ps

module socks5rp_in_stage
   import socks5rp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   socks5rp_req_if.sink req_ch,
   input  logic         take,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    load;

   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;
   assign valid_in     = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.restart   <= req_ch.restart;
         item_ff.data_byte <= req_ch.data_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/socks5rp_core.sv
`timescale 1ns / 1ps

module socks5rp_core
   import socks5rp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   phase_type   phase_ff, phase_in, cur_phase;
   logic        status_ff, status_in, cur_status;
   logic [2:0]  kind_ff, kind_in, cur_kind;
   logic [7:0]  name_length_ff, name_length_in, cur_name_length;
   logic [7:0]  byte_count_ff, byte_count_in, cur_byte_count;
   logic [7:0]  port_high_ff, port_high_in, cur_port_high;
   logic [15:0] port_ff, port_in, cur_port;
   logic [7:0]  b;
   logic [7:0]  target;
   logic [7:0]  count_inc;
   logic        av;

   assign b         = item.data_byte;
   assign count_inc = cur_byte_count + 8'd1;

   always_comb begin
      // restart clears the state before this byte is used
      if (item.restart) begin
         cur_phase       = PH_VERSION;
         cur_status      = 1'b0;
         cur_kind        = KIND_NONE;
         cur_name_length = 8'd0;
         cur_byte_count  = 8'd0;
         cur_port_high   = 8'd0;
         cur_port        = 16'd0;
      end else begin
         cur_phase       = phase_ff;
         cur_status      = status_ff;
         cur_kind        = kind_ff;
         cur_name_length = name_length_ff;
         cur_byte_count  = byte_count_ff;
         cur_port_high   = port_high_ff;
         cur_port        = port_ff;
      end
   end

   always_comb begin
      case (cur_kind)
         KIND_IPV4:   target = LEN_IPV4;
         KIND_IPV6:   target = LEN_IPV6;
         default:     target = cur_name_length;
      endcase
   end

   always_comb begin
      phase_in       = cur_phase;
      status_in      = cur_status;
      kind_in        = cur_kind;
      name_length_in = cur_name_length;
      byte_count_in  = cur_byte_count;
      port_high_in   = cur_port_high;
      port_in        = cur_port;
      av             = 1'b0;
      case (cur_phase)
         PH_VERSION: begin
            phase_in = (b == SOCKS_VER) ? PH_CMD : PH_ERROR;
         end
         PH_CMD: begin
            if (b == CMD_CONNECT) begin
               phase_in = PH_RSV;
            end else begin
               status_in = 1'b1;
               phase_in  = PH_ERROR;
            end
         end
         PH_RSV: begin
            phase_in = (b == RSV_BYTE) ? PH_ATYP : PH_ERROR;
         end
         PH_ATYP: begin
            if (b inside {{5'd0, KIND_IPV4}, {5'd0, KIND_IPV6}}) begin
               kind_in  = b[2:0];
               phase_in = PH_ADDR;
            end else if (b == {5'd0, KIND_DOMAIN}) begin
               kind_in  = b[2:0];
               phase_in = PH_NAMELEN;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_NAMELEN: begin
            if (b == 8'd0) begin
               phase_in = PH_ERROR;
            end else begin
               name_length_in = b;
               byte_count_in  = 8'd0;
               phase_in       = PH_ADDR;
            end
         end
         PH_ADDR: begin
            if (cur_kind inside {KIND_IPV4, KIND_IPV6, KIND_DOMAIN}) begin
               av            = 1'b1;
               byte_count_in = count_inc;
               if (count_inc == target) begin
                  byte_count_in = 8'd0;
                  phase_in      = PH_PORT;
               end
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_PORT: begin
            if (cur_byte_count == 8'd0) begin
               port_high_in  = b;
               byte_count_in = 8'd1;
            end else begin
               port_in       = {cur_port_high, b};
               byte_count_in = 8'd0;
               phase_in      = PH_END;
            end
         end
         PH_END: begin
            phase_in = (b == 8'd0) ? PH_END : PH_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_VERSION;
         status_ff      <= 1'b0;
         kind_ff        <= KIND_NONE;
         name_length_ff <= 8'd0;
         byte_count_ff  <= 8'd0;
         port_high_ff   <= 8'd0;
         port_ff        <= 16'd0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         status_ff      <= status_in;
         kind_ff        <= kind_in;
         name_length_ff <= name_length_in;
         byte_count_ff  <= byte_count_in;
         port_high_ff   <= port_high_in;
         port_ff        <= port_in;
      end
   end

   always_comb begin
      result.phase         = phase_code(phase_in);
      result.reply_status  = status_in;
      result.request_done  = (phase_in == PH_END);
      result.request_error = (phase_code(phase_in) == CODE_ERROR);
      result.addr_kind     = kind_in;
      result.addr_valid    = av;
      result.addr_byte     = av ? b : 8'd0;
      result.addr_index    = av ? cur_byte_count : 8'd0;
      result.dest_port     = port_in;
   end

endmodule

// File: sv/socks5rp_out_stage.sv
`timescale 1ns / 1ps

module socks5rp_out_stage
   import socks5rp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  rsp_type        result,
   output logic           can_load,
   socks5rp_rsp_if.source rsp_ch
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;
   logic    load;

   assign can_load = !valid_ff || rsp_ch.ready;
   assign load     = item_valid && can_load;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.phase         = result_ff.phase;
   assign rsp_ch.reply_status  = result_ff.reply_status;
   assign rsp_ch.request_done  = result_ff.request_done;
   assign rsp_ch.request_error = result_ff.request_error;
   assign rsp_ch.addr_kind     = result_ff.addr_kind;
   assign rsp_ch.addr_valid    = result_ff.addr_valid;
   assign rsp_ch.addr_byte     = result_ff.addr_byte;
   assign rsp_ch.addr_index    = result_ff.addr_index;
   assign rsp_ch.dest_port     = result_ff.dest_port;

endmodule

// File: verif/tb_socks5_request_parser.sv
`timescale 1ns / 1ps

module tb_socks5_request_parser;
   import socks5rp_pkg::*;

   localparam int RAND_ITEMS  = 850;
   localparam int QUIET_ITEMS = 150;
   localparam int HOLD_CYCLES = 120;
   localparam int WDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 8;

   typedef struct packed {
      logic        restart;
      logic [7:0]  data;
      logic        typed;
      logic [3:0]  phase;
      logic        status;
      logic [2:0]  kind;
      logic [15:0] port;
   } dir_row_type;

   // typed rows carry the expected phase, status, kind and port
   localparam dir_row_type DIR_TBL [0:24] = '{
      '{1'b0, 8'h00, 1'b1, CODE_ERROR, 1'b0, KIND_NONE,   16'h0000},
      '{1'b0, 8'hFF, 1'b1, CODE_ERROR, 1'b0, KIND_NONE,   16'h0000},
      '{1'b1, 8'h05, 1'b1, CODE_CMD,   1'b0, KIND_NONE,   16'h0000},
      '{1'b0, 8'h00, 1'b1, CODE_ERROR, 1'b1, KIND_NONE,   16'h0000},
      '{1'b1, 8'h05, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h01, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h01, 1'b1, CODE_ADDR,  1'b0, KIND_IPV4,   16'h0000},
      '{1'b0, 8'hFF, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'hAA, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h55, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'hFF, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'hFF, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b1, CODE_END,   1'b0, KIND_IPV4,   16'hFFFF},
      '{1'b0, 8'h01, 1'b1, CODE_ERROR, 1'b0, KIND_IPV4,   16'hFFFF},
      '{1'b1, 8'h05, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h01, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h03, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b1, CODE_ERROR, 1'b0, KIND_DOMAIN, 16'h0000},
      '{1'b1, 8'h05, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h01, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'h00, 1'b0, CODE_VERSION, 1'b0, KIND_NONE, 16'h0000},
      '{1'b0, 8'hFF, 1'b1, CODE_ERROR, 1'b0, KIND_NONE,   16'h0000}
   };

   logic clock;
   logic reset;

   socks5rp_req_if req_if ();
   socks5rp_rsp_if rsp_if ();

   socks5_request_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // parser state as predicted
   logic [3:0]  prd_phase;
   logic        prd_status;
   logic [2:0]  prd_kind;
   logic [7:0]  prd_name_len;
   logic [7:0]  prd_count;
   logic [7:0]  prd_port_high;
   logic [15:0] prd_port;

   rsp_type expected_rsp_q [$];
   req_type request_bytes_q [$];
   int      mismatch_cnt = 0;
   int      rsp_idx = 0;
   int      stall_cnt = 0;
   bit      send_idle = 1'b1;
   bit      recv_idle = 1'b1;
   bit      hold_req  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_parser();
      prd_phase     = CODE_VERSION;
      prd_status    = 1'b0;
      prd_kind      = KIND_NONE;
      prd_name_len  = 8'd0;
      prd_count     = 8'd0;
      prd_port_high = 8'd0;
      prd_port      = 16'd0;
   endfunction

   function automatic rsp_type parse_byte(input logic restart, input logic [7:0] b);
      rsp_type    r;
      logic [7:0] target;
      logic       known;
      r      = '0;
      target = 8'd0;
      known  = 1'b1;
      if (restart) begin
         clear_parser();
      end
      case (prd_phase)
         CODE_VERSION: prd_phase = (b == SOCKS_VER) ? CODE_CMD : CODE_ERROR;
         CODE_CMD: begin
            if (b == CMD_CONNECT) begin
               prd_phase = CODE_RSV;
            end else begin
               prd_status = 1'b1;
               prd_phase  = CODE_ERROR;
            end
         end
         CODE_RSV: prd_phase = (b == RSV_BYTE) ? CODE_ATYP : CODE_ERROR;
         CODE_ATYP: begin
            if (b inside {{5'd0, KIND_IPV4}, {5'd0, KIND_IPV6}}) begin
               prd_kind  = b[2:0];
               prd_phase = CODE_ADDR;
            end else if (b == {5'd0, KIND_DOMAIN}) begin
               prd_kind  = b[2:0];
               prd_phase = CODE_NAMELEN;
            end else begin
               prd_phase = CODE_ERROR;
            end
         end
         CODE_NAMELEN: begin
            if (b == 8'd0) begin
               prd_phase = CODE_ERROR;
            end else begin
               prd_name_len = b;
               prd_count    = 8'd0;
               prd_phase    = CODE_ADDR;
            end
         end
         CODE_ADDR: begin
            case (prd_kind)
               KIND_IPV4:   target = LEN_IPV4;
               KIND_IPV6:   target = LEN_IPV6;
               KIND_DOMAIN: target = prd_name_len;
               default:     known = 1'b0;
            endcase
            if (!known) begin
               prd_phase = CODE_ERROR;
            end else begin
               r.addr_valid = 1'b1;
               r.addr_byte  = b;
               r.addr_index = prd_count;
               prd_count    = prd_count + 8'd1;
               if (prd_count == target) begin
                  prd_count = 8'd0;
                  prd_phase = CODE_PORT;
               end
            end
         end
         CODE_PORT: begin
            if (prd_count == 8'd0) begin
               prd_port_high = b;
               prd_count     = 8'd1;
            end else begin
               prd_port  = {prd_port_high, b};
               prd_count = 8'd0;
               prd_phase = CODE_END;
            end
         end
         CODE_END: prd_phase = (b == 8'd0) ? CODE_END : CODE_ERROR;
         default:  prd_phase = CODE_ERROR;
      endcase
      r.phase         = prd_phase;
      r.reply_status  = prd_status;
      r.request_done  = (prd_phase == CODE_END);
      r.request_error = (prd_phase == CODE_ERROR);
      r.addr_kind     = prd_kind;
      r.dest_port     = prd_port;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_cnt < 100) begin
         $display("MISMATCH @%0t: %s", $realtime, msg);
      end
      mismatch_cnt++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("item %0d %s got %h exp %h", rsp_idx, name, got, want));
      end
   endtask

   // one request byte; waits for acceptance and records what should come back
   task automatic offer_byte(input req_type it, input bit typed, input rsp_type typed_rsp);
      rsp_type prd;
      if (send_idle && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.restart   <= it.restart;
      req_if.data_byte <= it.data_byte;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      prd = parse_byte(it.restart, it.data_byte);
      expected_rsp_q.push_back(typed ? typed_rsp : prd);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed requests, some with one corrupted byte, some pure noise
   task automatic build_request();
      logic [7:0] bytes [$];
      int         kind_sel;
      int         len;
      int         mode;
      logic [15:0] port;
      req_type    it;
      bytes    = {};
      kind_sel = $urandom_range(0, 2);
      mode     = $urandom_range(0, 9);
      bytes.push_back(SOCKS_VER);
      bytes.push_back(CMD_CONNECT);
      bytes.push_back(RSV_BYTE);
      if (kind_sel == 0) begin
         bytes.push_back({5'd0, KIND_IPV4});
         len = int'(LEN_IPV4);
      end else if (kind_sel == 1) begin
         bytes.push_back({5'd0, KIND_IPV6});
         len = int'(LEN_IPV6);
      end else begin
         bytes.push_back({5'd0, KIND_DOMAIN});
         len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(1, 8);
         bytes.push_back(len[7:0]);
      end
      repeat (len) bytes.push_back(8'($urandom));
      case ($urandom_range(0, 7))
         0:       port = 16'h0000;
         1:       port = 16'hFFFF;
         default: port = 16'($urandom);
      endcase
      bytes.push_back(port[15:8]);
      bytes.push_back(port[7:0]);
      repeat ($urandom_range(0, 2)) bytes.push_back(8'h00);
      if ($urandom_range(0, 3) == 0) begin
         bytes.push_back(8'($urandom));
      end
      if (mode inside {[7:8]}) begin
         bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom);
      end else if (mode == 9) begin
         bytes = {};
         repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
      end
      foreach (bytes[i]) begin
         it.data_byte = bytes[i];
         if (i == 0) begin
            it.restart = ($urandom_range(0, 7) != 0);
         end else begin
            it.restart = ($urandom_range(0, 99) == 0);
         end
         request_bytes_q.push_back(it);
      end
   endtask

   // receiver: random bursts of back-pressure, one long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            stall_cnt = 0;
            while (stall_cnt < HOLD_CYCLES - 1) begin
               @(negedge clock);
               stall_cnt++;
            end
            hold_req = 1'b0;
         end else if (recv_idle && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.phase         = rsp_if.phase;
         got.reply_status  = rsp_if.reply_status;
         got.request_done  = rsp_if.request_done;
         got.request_error = rsp_if.request_error;
         got.addr_kind     = rsp_if.addr_kind;
         got.addr_valid    = rsp_if.addr_valid;
         got.addr_byte     = rsp_if.addr_byte;
         got.addr_index    = rsp_if.addr_index;
         got.dest_port     = rsp_if.dest_port;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("item %0d arrived with nothing expected", rsp_idx));
         end else begin
            rsp_type want;
            want = expected_rsp_q.pop_front();
            check_field("phase", 16'(got.phase), 16'(want.phase));
            check_field("reply_status", 16'(got.reply_status), 16'(want.reply_status));
            check_field("request_done", 16'(got.request_done), 16'(want.request_done));
            check_field("request_error", 16'(got.request_error),
                        16'(want.request_error));
            check_field("addr_kind", 16'(got.addr_kind), 16'(want.addr_kind));
            check_field("addr_valid", 16'(got.addr_valid), 16'(want.addr_valid));
            check_field("addr_byte", 16'(got.addr_byte), 16'(want.addr_byte));
            check_field("addr_index", 16'(got.addr_index), 16'(want.addr_index));
            check_field("dest_port", got.dest_port, want.dest_port);
         end
         rsp_idx++;
      end
   end

   // watchdog on cycles with no movement on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      rsp_type tr;
      req_type it;
      int      n;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.restart   = 1'b0;
      req_if.data_byte = 8'h00;
      clear_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIR_TBL[i]) begin
         tr               = '0;
         tr.phase         = DIR_TBL[i].phase;
         tr.reply_status  = DIR_TBL[i].status;
         tr.request_done  = (DIR_TBL[i].phase == CODE_END);
         tr.request_error = (DIR_TBL[i].phase == CODE_ERROR);
         tr.addr_kind     = DIR_TBL[i].kind;
         tr.dest_port     = DIR_TBL[i].port;
         it.restart       = DIR_TBL[i].restart;
         it.data_byte     = DIR_TBL[i].data;
         offer_byte(it, DIR_TBL[i].typed, tr);
      end
      drain_results();

      while (request_bytes_q.size() < RAND_ITEMS) build_request();
      n = request_bytes_q.size();
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) begin
            hold_req = 1'b1;
         end
         if (i == n / 2) begin
            drain_results();
         end
         if (i == n - QUIET_ITEMS) begin
            send_idle = 1'b0;
            recv_idle = 1'b0;
         end
         offer_byte(request_bytes_q[i], 1'b0, '0);
      end
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_rsp_q.size() != 0) begin
         report_mismatch("results still expected at end of run");
      end
      if (mismatch_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
